// ===== rtl/core/can_record_deframer_assert.svh =====
// can_record_deframer_assert.svh: assertion macros for the record deframer
// no dependencies; included by the files that carry concurrent assertions
`ifndef CAN_RECORD_DEFRAMER_ASSERT_SVH
`define CAN_RECORD_DEFRAMER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define CRD_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// condition holds in the cycle after the trigger
`define CRD_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ===== rtl/core/crd_pkg.sv =====
// crd_pkg: types and constants shared by the can record deframer
// no dependencies; imported by crd_frame_ctrl and can_record_deframer
`default_nettype none

package crd_pkg;

   // result status codes
   typedef enum logic [2:0] {
      ST_IGNORED    = 3'd0,
      ST_STARTED    = 3'd1,
      ST_STORED     = 3'd2,
      ST_COMMITTED  = 3'd3,
      ST_ABORTED    = 3'd4,
      ST_READ_OK    = 3'd5,
      ST_READ_EMPTY = 3'd6
   } status_type;

   // request kinds
   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // frame lengths of interest
   localparam logic [3:0] LEN_FULL = 4'd8;
   localparam logic [3:0] LEN_TAIL = 4'd4;

   // framing patterns, byte 0 in the low bits
   localparam logic [47:0] START_PATTERN = 48'h1002_AA55_AA55;
   localparam logic [31:0] HEAD_MARK     = 32'hAA55_AA55;
   localparam logic [31:0] TAIL_MARK     = 32'hCC66_CC66;

   // register index of the descramble key (paddr bit 2)
   localparam logic CSR_KEY_INDEX = 1'b0;

   // result of one word, handed from the controller to the output register
   typedef struct packed {
      status_type status;
      logic       record_valid;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/crd_ring_mem.sv =====
// crd_ring_mem: ring of 64-bit record words, one write and one registered read
// no dependencies; instantiated by can_record_deframer
`default_nettype none

module crd_ring_mem #(
   parameter int DEPTH = 96,
   parameter int AW    = 7
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [63:0]   wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [63:0]        rd_data
);

   logic [63:0] ring_ff [DEPTH];
   logic [63:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/crd_frame_ctrl.sv =====
// crd_frame_ctrl: packet state, write pointer tracking and ring addressing
// depends on crd_pkg; drives the ring memory ports and the result word
`default_nettype none

module crd_frame_ctrl
   import crd_pkg::*;
#(
   parameter int RECORD_BYTES = 48,
   parameter int RECORD_COUNT = 16,
   parameter int AW           = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic          item_type,
   input  wire logic [3:0]    item_length,
   input  wire logic [63:0]   item_data,
   input  wire logic [2:0]    item_word,
   input  wire logic [7:0]    key,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [63:0]        wr_data,
   output logic               rd_en,
   output logic [AW-1:0]      rd_addr,
   output result_type         result
);

   localparam int REC_WORDS = (RECORD_BYTES + 7) / 8;
   localparam int END_WORDS = (RECORD_COUNT * RECORD_BYTES + 7) / 8;
   localparam int OW        = $clog2(RECORD_BYTES);
   localparam int SW        = AW + 6;

   logic          in_packet_ff,    in_packet_in;
   logic [AW-1:0] write_word_ff,   write_word_in;
   logic [OW-1:0] write_off_ff,    write_off_in;
   logic [AW-1:0] packet_start_ff, packet_start_in;
   logic [OW-1:0] packet_off_ff,   packet_off_in;
   logic [AW-1:0] latest_start_ff, latest_start_in;
   logic          latest_valid_ff, latest_valid_in;

   logic [AW:0]   word_inc;
   logic [OW:0]   off_inc;
   logic [SW-1:0] read_idx;
   logic [SW-1:0] read_sum;
   logic          is_start;
   logic          is_marker;
   logic          is_tail;
   status_type    status;

   // frame pattern decode
   assign is_start  = (item_length == LEN_FULL) && (item_data[47:0] == START_PATTERN);
   assign is_marker = (item_data[31:0] == HEAD_MARK) || (item_data[63:32] == TAIL_MARK);
   assign is_tail   = (item_data[31:0] == TAIL_MARK) && (write_off_ff == '0);

   // next write word and its byte offset within a record
   assign word_inc = {1'b0, write_word_ff} + (AW+1)'(1);
   assign off_inc  = {1'b0, write_off_ff} + (OW+1)'(8);

   // read address in the latest record, index saturated, wrapped at ring end
   assign read_idx = (SW'(item_word) > SW'(REC_WORDS - 1)) ? SW'(REC_WORDS - 1)
                                                           : SW'(item_word);
   assign read_sum = SW'(latest_start_ff) + read_idx;
   assign rd_addr  = (read_sum >= SW'(END_WORDS)) ? AW'(read_sum - SW'(END_WORDS))
                                                  : AW'(read_sum);

   // descrambled store data
   assign wr_addr = write_word_ff;
   assign wr_data = item_data ^ {8{key}};

   // packet state update
   always_comb begin
      in_packet_in    = in_packet_ff;
      write_word_in   = write_word_ff;
      write_off_in    = write_off_ff;
      packet_start_in = packet_start_ff;
      packet_off_in   = packet_off_ff;
      latest_start_in = latest_start_ff;
      latest_valid_in = latest_valid_ff;
      status          = ST_IGNORED;
      wr_en           = 1'b0;
      rd_en           = 1'b0;
      if (step) begin
         if (item_type == REQ_READ) begin
            if (latest_valid_ff) begin
               status = ST_READ_OK;
               rd_en  = 1'b1;
            end else begin
               status = ST_READ_EMPTY;
            end
         end else if (!in_packet_ff) begin
            if (is_start) begin
               in_packet_in    = 1'b1;
               packet_start_in = write_word_ff;
               packet_off_in   = write_off_ff;
               status          = ST_STARTED;
            end
         end else if ((item_length == LEN_FULL) && !is_marker) begin
            // plain data frame: store and advance, wrapping at the ring end
            wr_en  = 1'b1;
            status = ST_STORED;
            if (word_inc >= (AW+1)'(END_WORDS)) begin
               write_word_in = '0;
               write_off_in  = '0;
            end else begin
               write_word_in = word_inc[AW-1:0];
               write_off_in  = (off_inc >= (OW+1)'(RECORD_BYTES))
                             ? OW'(off_inc - (OW+1)'(RECORD_BYTES))
                             : off_inc[OW-1:0];
            end
         end else if ((item_length == LEN_TAIL) && is_tail) begin
            latest_start_in = packet_start_ff;
            latest_valid_in = 1'b1;
            in_packet_in    = 1'b0;
            status          = ST_COMMITTED;
         end else begin
            // marker, bad tail or bad length: rewind
            write_word_in = packet_start_ff;
            write_off_in  = packet_off_ff;
            in_packet_in  = 1'b0;
            status        = ST_ABORTED;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff    <= 1'b0;
         write_word_ff   <= '0;
         write_off_ff    <= '0;
         packet_start_ff <= '0;
         packet_off_ff   <= '0;
         latest_start_ff <= '0;
         latest_valid_ff <= 1'b0;
      end else begin
         in_packet_ff    <= in_packet_in;
         write_word_ff   <= write_word_in;
         write_off_ff    <= write_off_in;
         packet_start_ff <= packet_start_in;
         packet_off_ff   <= packet_off_in;
         latest_start_ff <= latest_start_in;
         latest_valid_ff <= latest_valid_in;
      end
   end

   assign result.status       = status;
   assign result.record_valid = latest_valid_in;

endmodule

`default_nettype wire

// ===== rtl/core/can_record_deframer.sv =====
// can_record_deframer: top level, input register, result register, key csr
// depends on crd_pkg, crd_frame_ctrl, crd_ring_mem and the assertion macros
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  req_type, frame_length, frame_data, read_word
//   rsp       out        rsp_valid / rsp_stall  status, read_data, record_valid
//   csr       in         apb psel/penable       descramble_key at byte address 0
//
// one word is taken per cycle while req_stall is low; its result reaches the rsp ports through the
// input register, then the result register with the ring read data register.
// the ring memory has one write port and one registered read port, each used at most once per word.
// reset is synchronous and clears packet state, pointers, valid flags and the key.
// a stalled result holds the input register; the input stalls only while both are full.
`default_nettype none

module can_record_deframer
   import crd_pkg::*;
#(
   parameter int RECORD_BYTES = 48,
   parameter int RECORD_COUNT = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [3:0]  req_frame_length,
   input  wire logic [63:0] req_frame_data,
   input  wire logic [2:0]  req_read_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [63:0]      rsp_read_data,
   output logic             rsp_record_valid,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

`include "can_record_deframer_assert.svh"

   localparam int END_WORDS = (RECORD_COUNT * RECORD_BYTES + 7) / 8;
   localparam int AW        = $clog2(END_WORDS);

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_type_ff;
   logic [3:0]    s1_length_ff;
   logic [63:0]   s1_data_ff;
   logic [2:0]    s1_word_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff;
   logic          rsp_record_valid_ff;
   logic [7:0]    key_ff;
   logic          req_accept;
   logic          advance;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [63:0]   wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [63:0]   rd_data;
   result_type    result;

   // handshake
   assign advance     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !advance;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_type_ff   <= req_type;
         s1_length_ff <= req_frame_length;
         s1_data_ff   <= req_frame_data;
         s1_word_ff   <= req_read_word;
      end
   end

   // key register
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (psel && penable && pwrite && (paddr[2] == CSR_KEY_INDEX)) begin
         key_ff <= pwdata[7:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_KEY_INDEX) ? {24'd0, key_ff} : '0;

   crd_frame_ctrl #(
      .RECORD_BYTES (RECORD_BYTES),
      .RECORD_COUNT (RECORD_COUNT),
      .AW           (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item_type   (s1_type_ff),
      .item_length (s1_length_ff),
      .item_data   (s1_data_ff),
      .item_word   (s1_word_ff),
      .key         (key_ff),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .result      (result)
   );

   crd_ring_mem #(
      .DEPTH (END_WORDS),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_status_ff       <= result.status;
         rsp_record_valid_ff <= result.record_valid;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_record_valid = rsp_record_valid_ff;
   assign rsp_read_data    = (rsp_status_ff == ST_READ_OK) ? rd_data : '0;

   // checks
   `CRD_ASSERT_SAME(a_empty_means_no_record, clock, reset,
      rsp_valid_ff && (rsp_status_ff == ST_READ_EMPTY), !rsp_record_valid_ff,
      "read empty reported with a committed record")
   `CRD_ASSERT_SAME(a_commit_sets_record, clock, reset,
      rsp_valid_ff && ((rsp_status_ff == ST_COMMITTED) || (rsp_status_ff == ST_READ_OK)),
      rsp_record_valid_ff, "commit or read ok without record valid")
   `CRD_ASSERT_NEXT(a_held_word_kept, clock, reset,
      s1_valid_ff && !advance, s1_valid_ff && $stable(s1_data_ff),
      "held input word lost or changed")

endmodule

`default_nettype wire
